FILE: rtl/bga_pkg.sv
// shared constants and codes for the banded affine-gap alignment block
package bga_pkg;

    // parameter defaults
    localparam int MAX_SEQ_LEN_DEF = 32;
    localparam int BAND_DIAG_DEF   = 15;
    localparam int SCORE_W_DEF     = 10;

    // fixed field widths, limits and the edge value
    localparam int POS_W     = 6;
    localparam int CNT_W     = 7;
    localparam int TYPE_W    = 3;
    localparam int COST_W    = 5;
    localparam int LEN_W     = 6;
    localparam int BASE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int MIN_LEN   = 16;
    localparam int EDGE_VAL  = 99;
    localparam int MAX_RES   = 64;
    localparam int RES_IDX_W = 6;

    // traceback pointer codes
    localparam logic [1:0] DIR_SUB = 2'd0;
    localparam logic [1:0] DIR_INS = 2'd1;
    localparam logic [1:0] DIR_DEL = 2'd2;

    // edit codes
    localparam logic [TYPE_W-1:0] ED_END = 3'd0;
    localparam logic [TYPE_W-1:0] ED_SUB = 3'd1;
    localparam logic [TYPE_W-1:0] ED_INS = 3'd2;
    localparam logic [TYPE_W-1:0] ED_DEL = 3'd3;
    localparam logic [TYPE_W-1:0] ED_ERR = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LEN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_OPEN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_EXTEND = 2'd3;

endpackage

FILE: rtl/bga_alu.sv
// shared saturating add-pair and compare unit
module bga_alu #(
    parameter int SCORE_W = bga_pkg::SCORE_W_DEF
) (
    input  logic [SCORE_W-1:0] a_in,
    input  logic [SCORE_W-1:0] b_in,
    input  logic [SCORE_W-1:0] c_in,
    input  logic [SCORE_W-1:0] d_in,
    output logic [SCORE_W-1:0] y_out,
    output logic               lt_out
);

    logic [SCORE_W:0]   sum_ab;
    logic [SCORE_W:0]   sum_cd;
    logic [SCORE_W-1:0] sat_ab;
    logic [SCORE_W-1:0] sat_cd;

    always_comb begin
        sum_ab = {1'b0, a_in} + {1'b0, b_in};
        sum_cd = {1'b0, c_in} + {1'b0, d_in};
        sat_ab = sum_ab[SCORE_W] ? '1 : sum_ab[SCORE_W-1:0];
        sat_cd = sum_cd[SCORE_W] ? '1 : sum_cd[SCORE_W-1:0];
        // strict less: ties go to the second pair
        lt_out = (sat_ab < sat_cd);
        y_out  = lt_out ? sat_ab : sat_cd;
    end

endmodule

FILE: rtl/banded_affine_gap_alignment.sv
// top level: loader, matrix sequencer, traceback and result output
// run: the word completing a sequence pair starts the run, which does boundary set-up,
//   the band fill, the best-cell scan, the traceback and the result output in that order
// throughput: loading words are taken one per cycle while idle; the block is busy for the whole run,
//   bounded by the single shared add/compare unit and the score memory's one read and one write port
// reset: aresetn synchronous, active low; clears control, counters and config registers;
//   matrix memories are not cleared, every entry read is written earlier in the same run
module banded_affine_gap_alignment #(
    parameter int MAX_SEQ_LEN    = bga_pkg::MAX_SEQ_LEN_DEF,
    parameter int BAND_DIAGONALS = bga_pkg::BAND_DIAG_DEF,
    parameter int SCORE_WIDTH    = bga_pkg::SCORE_W_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // first_base[1:0], second_base[3:2], zero pad
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // edit_type[2:0], row_pos[8:3], col_pos[14:9],
                                   // edit_count[21:15], zero pad
    output logic        m_tlast,   // last_edit
    // configuration writes
    input  logic                           cfg_wr_en,
    input  logic [bga_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bga_pkg::LEN_W-1:0]      cfg_wdata
);

    localparam int SIDE      = MAX_SEQ_LEN + 1;
    localparam int HALF      = BAND_DIAGONALS / 2 + 1;
    localparam int DEPTH     = SIDE * SIDE;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int VG_W      = $clog2(SIDE);
    localparam int SEQ_IDX_W = $clog2(MAX_SEQ_LEN);
    localparam int POS_W     = bga_pkg::POS_W;
    localparam int CNT_W     = bga_pkg::CNT_W;
    localparam int TYPE_W    = bga_pkg::TYPE_W;
    localparam int RES_W     = TYPE_W + 2 * POS_W;

    localparam logic [POS_W-1:0]       HALF_P = POS_W'(HALF);
    localparam logic [SCORE_WIDTH-1:0] EDGE   = SCORE_WIDTH'(bga_pkg::EDGE_VAL);

    // sequencer states
    typedef enum logic [24:0] {
        S_IDLE    = 25'h0000001,
        S_INIT_A  = 25'h0000002,
        S_INIT_B  = 25'h0000004,
        S_ROW_W   = 25'h0000008,
        S_ROW_RL  = 25'h0000010,
        S_ROW_RD  = 25'h0000020,
        S_ROW_DG  = 25'h0000040,
        S_CELL_RU = 25'h0000080,
        S_CELL_Q  = 25'h0000100,
        S_CELL_G  = 25'h0000200,
        S_CELL_D  = 25'h0000400,
        S_ROW_END = 25'h0000800,
        S_BST_RD  = 25'h0001000,
        S_BST_CMP = 25'h0002000,
        S_BST_END = 25'h0004000,
        S_TS_RD   = 25'h0008000,
        S_TS_CHK  = 25'h0010000,
        S_TM_TEST = 25'h0020000,
        S_TM_DIR  = 25'h0040000,
        S_TM_S1   = 25'h0080000,
        S_TM_S2   = 25'h0100000,
        S_TM_S3   = 25'h0200000,
        S_ERR     = 25'h0400000,
        S_EM_RD   = 25'h0800000,
        S_EM_LD   = 25'h1000000
    } state_t;

    // configuration registers
    logic [bga_pkg::LEN_W-1:0]  seq_len_reg;
    logic [bga_pkg::COST_W-1:0] cost_mismatch_reg;
    logic [bga_pkg::COST_W-1:0] cost_gap_open_reg;
    logic [bga_pkg::COST_W-1:0] cost_gap_extend_reg;

    // control and datapath registers
    state_t                 state_reg, state_next;
    logic [POS_W-1:0]       load_cnt_reg, load_cnt_next;
    logic [POS_W-1:0]       i_reg, i_next;
    logic [POS_W-1:0]       j_reg, j_next;
    logic [POS_W-1:0]       k_reg, k_next;
    logic                   phase_reg, phase_next;
    logic [SCORE_WIDTH-1:0] v_reg, v_next;
    logic [SCORE_WIDTH-1:0] left_reg, left_next;
    logic [SCORE_WIDTH-1:0] diag_reg, diag_next;
    logic [SCORE_WIDTH-1:0] up_reg, up_next;
    logic [SCORE_WIDTH-1:0] h_reg, h_next;
    logic [SCORE_WIDTH-1:0] p_reg, p_next;
    logic [SCORE_WIDTH-1:0] q_reg, q_next;
    logic [SCORE_WIDTH-1:0] g_reg, g_next;
    logic [1:0]             dir_reg, dir_next;
    logic [SCORE_WIDTH-1:0] best_score_reg, best_score_next;
    logic [POS_W-1:0]       best_row_reg, best_row_next;
    logic [POS_W-1:0]       best_col_reg, best_col_next;
    logic [SCORE_WIDTH-1:0] s1_reg, s1_next;
    logic [CNT_W-1:0]       n_reg, n_next;
    logic                   out_valid_reg, out_valid_next;
    logic [TYPE_W-1:0]      out_type_reg, out_type_next;
    logic [POS_W-1:0]       out_row_reg, out_row_next;
    logic [POS_W-1:0]       out_col_reg, out_col_next;
    logic [CNT_W-1:0]       out_cnt_reg, out_cnt_next;
    logic                   out_last_reg, out_last_next;

    // sequence buffers
    logic [bga_pkg::BASE_W-1:0] fbuf_reg [MAX_SEQ_LEN];
    logic [bga_pkg::BASE_W-1:0] sbuf_reg [MAX_SEQ_LEN];

    // memories
    logic [SCORE_WIDTH-1:0] score_mem [DEPTH];
    logic [1:0]             dir_mem   [DEPTH];
    logic [SCORE_WIDTH-1:0] vg_mem    [SIDE];
    logic [RES_W-1:0]       res_mem   [bga_pkg::MAX_RES];

    logic                   score_we;
    logic [ADDR_W-1:0]      score_waddr, score_raddr;
    logic [SCORE_WIDTH-1:0] score_wdata, score_q;
    logic                   dir_we;
    logic [ADDR_W-1:0]      dir_waddr, dir_raddr;
    logic [1:0]             dir_wdata, dir_q;
    logic                   vg_we;
    logic [VG_W-1:0]        vg_waddr, vg_raddr;
    logic [SCORE_WIDTH-1:0] vg_wdata, vg_q;
    logic                       res_we;
    logic [bga_pkg::RES_IDX_W-1:0] res_waddr, res_raddr;
    logic [RES_W-1:0]           res_wdata, res_q;

    // shared unit
    logic [SCORE_WIDTH-1:0] alu_a, alu_b, alu_c, alu_d, alu_y;
    logic                   alu_lt;

    // derived geometry
    logic                   s_acc;
    logic [POS_W-1:0]       eff_len;     // also the last matrix index
    logic [POS_W-1:0]       lo_col, hi_col, row0;
    logic [POS_W:0]         i_plus_h;
    logic [POS_W:0]         hi_raw;
    logic                   mis;
    logic [SCORE_WIDTH-1:0] cm_w, go_w, ge_w;
    logic [CNT_W-1:0]       k_plus1;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-1:0] r,
                                                    input logic [POS_W-1:0] c);
        cell_addr = ADDR_W'(r) * ADDR_W'(SIDE) + ADDR_W'(c);
    endfunction

    function automatic logic in_band(input logic [POS_W-1:0] r, input logic [POS_W-1:0] c,
                                     input logic [POS_W-1:0] last);
        logic [POS_W-1:0] diff;
        diff    = (r > c) ? r - c : c - r;
        in_band = (r != '0) && (c != '0) && (r <= last) && (c <= last) && (diff < HALF_P);
    endfunction

    bga_alu #(
        .SCORE_W (SCORE_WIDTH)
    ) u_alu (
        .a_in   (alu_a),
        .b_in   (alu_b),
        .c_in   (alu_c),
        .d_in   (alu_d),
        .y_out  (alu_y),
        .lt_out (alu_lt)
    );

    assign s_acc    = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_cnt_reg, out_col_reg, out_row_reg, out_type_reg};

    // geometry of the current row and run
    always_comb begin
        if (seq_len_reg < POS_W'(bga_pkg::MIN_LEN)) begin
            eff_len = POS_W'(bga_pkg::MIN_LEN);
        end else if (seq_len_reg > POS_W'(MAX_SEQ_LEN)) begin
            eff_len = POS_W'(MAX_SEQ_LEN);
        end else begin
            eff_len = seq_len_reg;
        end
        lo_col   = (i_reg >= HALF_P) ? i_reg - HALF_P + 1'b1 : POS_W'(1);
        hi_raw   = {1'b0, i_reg} + {1'b0, HALF_P} - 1'b1;
        hi_col   = (hi_raw > {1'b0, eff_len}) ? eff_len : hi_raw[POS_W-1:0];
        i_plus_h = {1'b0, i_reg} + {1'b0, HALF_P};
        row0     = eff_len + 1'b1 - HALF_P;
        mis      = (fbuf_reg[SEQ_IDX_W'(i_reg - 1'b1)] != sbuf_reg[SEQ_IDX_W'(j_reg - 1'b1)]);
        cm_w     = SCORE_WIDTH'(cost_mismatch_reg);
        go_w     = SCORE_WIDTH'(cost_gap_open_reg);
        ge_w     = SCORE_WIDTH'(cost_gap_extend_reg);
        k_plus1  = {1'b0, k_reg} + 1'b1;
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        load_cnt_next   = load_cnt_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        phase_next      = phase_reg;
        v_next          = v_reg;
        left_next       = left_reg;
        diag_next       = diag_reg;
        up_next         = up_reg;
        h_next          = h_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        g_next          = g_reg;
        dir_next        = dir_reg;
        best_score_next = best_score_reg;
        best_row_next   = best_row_reg;
        best_col_next   = best_col_reg;
        s1_next         = s1_reg;
        n_next          = n_reg;
        out_valid_next  = out_valid_reg;
        out_type_next   = out_type_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_cnt_next    = out_cnt_reg;
        out_last_next   = out_last_reg;

        score_we    = 1'b0;
        score_waddr = '0;
        score_wdata = '0;
        score_raddr = '0;
        dir_we      = 1'b0;
        dir_waddr   = '0;
        dir_wdata   = bga_pkg::DIR_SUB;
        dir_raddr   = '0;
        vg_we       = 1'b0;
        vg_waddr    = '0;
        vg_wdata    = '0;
        vg_raddr    = '0;
        res_we      = 1'b0;
        res_waddr   = n_reg[bga_pkg::RES_IDX_W-1:0];
        res_wdata   = '0;
        res_raddr   = k_reg;
        alu_a       = '0;
        alu_b       = '0;
        alu_c       = '0;
        alu_d       = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    if (load_cnt_reg + 1'b1 >= eff_len) begin
                        load_cnt_next = '0;
                        k_next        = '0;
                        v_next        = '0;
                        state_next    = S_INIT_A;
                    end else begin
                        load_cnt_next = load_cnt_reg + 1'b1;
                    end
                end
            end
            // boundary column and gap row
            S_INIT_A: begin
                score_we    = 1'b1;
                score_waddr = cell_addr(k_reg, '0);
                score_wdata = v_reg;
                vg_we       = 1'b1;
                vg_waddr    = VG_W'(k_reg);
                vg_wdata    = EDGE;
                state_next  = S_INIT_B;
            end
            // boundary row, next boundary value by the shared unit
            S_INIT_B: begin
                score_we    = 1'b1;
                score_waddr = cell_addr('0, k_reg);
                score_wdata = v_reg;
                alu_a       = v_reg;
                alu_b       = cm_w;
                alu_c       = v_reg;
                alu_d       = cm_w;
                v_next      = alu_y;
                if (k_reg == HALF_P) begin
                    i_next     = POS_W'(1);
                    state_next = S_ROW_W;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_INIT_A;
                end
            end
            S_ROW_W: begin
                if (i_reg >= HALF_P) begin
                    score_we    = 1'b1;
                    score_waddr = cell_addr(i_reg, lo_col - 1'b1);
                    score_wdata = EDGE;
                end
                h_next     = EDGE;
                j_next     = lo_col;
                state_next = S_ROW_RL;
            end
            S_ROW_RL: begin
                score_raddr = cell_addr(i_reg, lo_col - 1'b1);
                state_next  = S_ROW_RD;
            end
            S_ROW_RD: begin
                score_raddr = cell_addr(i_reg - 1'b1, lo_col - 1'b1);
                left_next   = score_q;
                state_next  = S_ROW_DG;
            end
            S_ROW_DG: begin
                diag_next  = score_q;
                state_next = S_CELL_RU;
            end
            // horizontal gap
            S_CELL_RU: begin
                score_raddr = cell_addr(i_reg - 1'b1, j_reg);
                vg_raddr    = VG_W'(j_reg);
                alu_a       = left_reg;
                alu_b       = go_w;
                alu_c       = h_reg;
                alu_d       = ge_w;
                p_next      = alu_y;
                state_next  = S_CELL_Q;
            end
            // vertical gap
            S_CELL_Q: begin
                alu_a      = score_q;
                alu_b      = go_w;
                alu_c      = vg_q;
                alu_d      = ge_w;
                q_next     = alu_y;
                up_next    = score_q;
                state_next = S_CELL_G;
            end
            // insertion only when strictly better than deletion
            S_CELL_G: begin
                alu_a      = p_reg;
                alu_c      = q_reg;
                g_next     = alu_y;
                dir_next   = alu_lt ? bga_pkg::DIR_INS : bga_pkg::DIR_DEL;
                state_next = S_CELL_D;
            end
            // diagonal wins only when strictly below the gap
            S_CELL_D: begin
                alu_a       = diag_reg;
                alu_b       = mis ? cm_w : '0;
                alu_c       = g_reg;
                score_we    = 1'b1;
                score_waddr = cell_addr(i_reg, j_reg);
                score_wdata = alu_y;
                dir_we      = 1'b1;
                dir_waddr   = cell_addr(i_reg, j_reg);
                dir_wdata   = alu_lt ? bga_pkg::DIR_SUB : dir_reg;
                vg_we       = 1'b1;
                vg_waddr    = VG_W'(j_reg);
                vg_wdata    = q_reg;
                h_next      = p_reg;
                left_next   = alu_y;
                diag_next   = up_reg;
                if (j_reg == hi_col) begin
                    state_next = S_ROW_END;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_CELL_RU;
                end
            end
            // out-of-band marker right of the band
            S_ROW_END: begin
                if (i_plus_h <= {1'b0, eff_len}) begin
                    score_we    = 1'b1;
                    score_waddr = cell_addr(i_reg, i_plus_h[POS_W-1:0]);
                    score_wdata = EDGE;
                    vg_we       = 1'b1;
                    vg_waddr    = VG_W'(i_plus_h[POS_W-1:0]);
                    vg_wdata    = EDGE;
                end
                if (i_reg == eff_len) begin
                    best_score_next = EDGE;
                    best_row_next   = '0;
                    best_col_next   = '0;
                    k_next          = row0;
                    phase_next      = 1'b0;
                    state_next      = S_BST_RD;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_ROW_W;
                end
            end
            // last column first, then last row
            S_BST_RD: begin
                score_raddr = phase_reg ? cell_addr(eff_len, k_reg) : cell_addr(k_reg, eff_len);
                state_next  = S_BST_CMP;
            end
            S_BST_CMP: begin
                alu_a = score_q;
                alu_c = best_score_reg;
                if (alu_lt) begin
                    best_score_next = score_q;
                    best_row_next   = phase_reg ? eff_len : k_reg;
                    best_col_next   = phase_reg ? k_reg : eff_len;
                end
                if (k_reg == eff_len) begin
                    if (phase_reg) begin
                        state_next = S_BST_END;
                    end else begin
                        phase_next = 1'b1;
                        k_next     = row0;
                        state_next = S_BST_RD;
                    end
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_BST_RD;
                end
            end
            S_BST_END: begin
                i_next     = best_row_reg;
                j_next     = best_col_reg;
                state_next = S_TS_RD;
            end
            // strip trailing indels
            S_TS_RD: begin
                if (!in_band(i_reg, j_reg, eff_len)) begin
                    state_next = S_ERR;
                end else begin
                    dir_raddr  = cell_addr(i_reg, j_reg);
                    state_next = S_TS_CHK;
                end
            end
            S_TS_CHK: begin
                priority case (dir_q)
                    bga_pkg::DIR_SUB: begin
                        res_we     = 1'b1;
                        res_waddr  = '0;
                        res_wdata  = {POS_W'(0), POS_W'(0), bga_pkg::ED_END};
                        n_next     = CNT_W'(1);
                        state_next = S_TM_TEST;
                    end
                    bga_pkg::DIR_INS: begin
                        j_next     = j_reg - 1'b1;
                        state_next = S_TS_RD;
                    end
                    bga_pkg::DIR_DEL: begin
                        i_next     = i_reg - 1'b1;
                        state_next = S_TS_RD;
                    end
                    default: state_next = S_ERR;
                endcase
            end
            // main traceback
            S_TM_TEST: begin
                if (!(i_reg > POS_W'(1) && j_reg > POS_W'(1))) begin
                    k_next     = '0;
                    state_next = S_EM_RD;
                end else if (!in_band(i_reg, j_reg, eff_len)) begin
                    state_next = S_ERR;
                end else begin
                    dir_raddr  = cell_addr(i_reg, j_reg);
                    state_next = S_TM_DIR;
                end
            end
            S_TM_DIR: begin
                priority case (dir_q)
                    bga_pkg::DIR_SUB: begin
                        i_next     = i_reg - 1'b1;
                        j_next     = j_reg - 1'b1;
                        state_next = S_TM_S1;
                    end
                    bga_pkg::DIR_INS: begin
                        j_next     = j_reg - 1'b1;
                        if (!n_reg[CNT_W-1]) begin
                            res_we    = 1'b1;
                            res_wdata = {j_reg - 1'b1, i_reg, bga_pkg::ED_INS};
                            n_next    = n_reg + 1'b1;
                        end
                        state_next = S_TM_TEST;
                    end
                    bga_pkg::DIR_DEL: begin
                        i_next     = i_reg - 1'b1;
                        if (!n_reg[CNT_W-1]) begin
                            res_we    = 1'b1;
                            res_wdata = {j_reg, i_reg - 1'b1, bga_pkg::ED_DEL};
                            n_next    = n_reg + 1'b1;
                        end
                        state_next = S_TM_TEST;
                    end
                    default: state_next = S_ERR;
                endcase
            end
            // substitution counts only where the score changed
            S_TM_S1: begin
                score_raddr = cell_addr(i_reg, j_reg);
                state_next  = S_TM_S2;
            end
            S_TM_S2: begin
                score_raddr = cell_addr(i_reg - 1'b1, j_reg - 1'b1);
                s1_next     = score_q;
                state_next  = S_TM_S3;
            end
            S_TM_S3: begin
                if (score_q != s1_reg && !n_reg[CNT_W-1]) begin
                    res_we    = 1'b1;
                    res_wdata = {j_reg, i_reg, bga_pkg::ED_SUB};
                    n_next    = n_reg + 1'b1;
                end
                state_next = S_TM_TEST;
            end
            // single error word replaces the whole list
            S_ERR: begin
                n_next         = CNT_W'(1);
                k_next         = '0;
                out_valid_next = 1'b1;
                out_type_next  = bga_pkg::ED_ERR;
                out_row_next   = i_reg;
                out_col_next   = j_reg;
                out_cnt_next   = CNT_W'(1);
                out_last_next  = 1'b1;
                state_next     = S_EM_LD;
            end
            S_EM_RD: begin
                res_raddr  = k_reg;
                state_next = S_EM_LD;
            end
            // load the output register, then hold until taken
            S_EM_LD: begin
                if (!out_valid_reg) begin
                    out_valid_next = 1'b1;
                    out_type_next  = res_q[TYPE_W-1:0];
                    out_row_next   = res_q[TYPE_W+POS_W-1:TYPE_W];
                    out_col_next   = res_q[RES_W-1:TYPE_W+POS_W];
                    out_cnt_next   = n_reg;
                    out_last_next  = (k_plus1 == n_reg);
                end else if (m_tready) begin
                    out_valid_next = 1'b0;
                    if (out_last_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_EM_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= S_IDLE;
            load_cnt_reg        <= '0;
            best_score_reg      <= EDGE;
            best_row_reg        <= '0;
            best_col_reg        <= '0;
            n_reg               <= '0;
            out_valid_reg       <= 1'b0;
            h_reg               <= '0;
            seq_len_reg         <= bga_pkg::LEN_W'(32);
            cost_mismatch_reg   <= bga_pkg::COST_W'(1);
            cost_gap_open_reg   <= bga_pkg::COST_W'(2);
            cost_gap_extend_reg <= bga_pkg::COST_W'(1);
        end else begin
            state_reg      <= state_next;
            load_cnt_reg   <= load_cnt_next;
            best_score_reg <= best_score_next;
            best_row_reg   <= best_row_next;
            best_col_reg   <= best_col_next;
            n_reg          <= n_next;
            out_valid_reg  <= out_valid_next;
            h_reg          <= h_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    bga_pkg::CFG_SEQ_LEN:    seq_len_reg         <= cfg_wdata;
                    bga_pkg::CFG_MISMATCH:   cost_mismatch_reg   <= cfg_wdata[bga_pkg::COST_W-1:0];
                    bga_pkg::CFG_GAP_OPEN:   cost_gap_open_reg   <= cfg_wdata[bga_pkg::COST_W-1:0];
                    bga_pkg::CFG_GAP_EXTEND: cost_gap_extend_reg <= cfg_wdata[bga_pkg::COST_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        i_reg         <= i_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        phase_reg     <= phase_next;
        v_reg         <= v_next;
        left_reg      <= left_next;
        diag_reg      <= diag_next;
        up_reg        <= up_next;
        p_reg         <= p_next;
        q_reg         <= q_next;
        g_reg         <= g_next;
        dir_reg       <= dir_next;
        s1_reg        <= s1_next;
        out_type_reg  <= out_type_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_cnt_reg   <= out_cnt_next;
        out_last_reg  <= out_last_next;
        if (s_acc) begin
            fbuf_reg[SEQ_IDX_W'(load_cnt_reg)] <= s_tdata[1:0];
            sbuf_reg[SEQ_IDX_W'(load_cnt_reg)] <= s_tdata[3:2];
        end
    end

    // matrix, gap row and result memories
    always_ff @(posedge aclk) begin
        if (score_we) begin
            score_mem[score_waddr] <= score_wdata;
        end
        score_q <= score_mem[score_raddr];
        if (dir_we) begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
        dir_q <= dir_mem[dir_raddr];
        if (vg_we) begin
            vg_mem[vg_waddr] <= vg_wdata;
        end
        vg_q <= vg_mem[vg_raddr];
        if (res_we) begin
            res_mem[res_waddr] <= res_wdata;
        end
        res_q <= res_mem[res_raddr];
    end

    // loading and result output never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result word is pending");

    // only real pointer codes are stored
    a_dir_code: assert property (@(posedge aclk) disable iff (!aresetn)
        dir_we |-> (dir_wdata == bga_pkg::DIR_SUB || dir_wdata == bga_pkg::DIR_INS ||
                    dir_wdata == bga_pkg::DIR_DEL))
        else $error("bad traceback pointer written");

    // the last word carries the final index of the list
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (k_plus1 == n_reg && out_cnt_reg == n_reg))
        else $error("last flag out of step with result count");

    // block returns to loading right after the last word
    a_back_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("block not idle after last result word");

endmodule

FILE: tb/tb.sv
// self-checking testbench for the banded affine-gap alignment block
`timescale 1ns / 100ps

module tb;

    localparam int SIDE      = bga_pkg::MAX_SEQ_LEN_DEF + 1;
    localparam int HALF      = bga_pkg::BAND_DIAG_DEF / 2 + 1;
    localparam int SCORE_TOP = (1 << bga_pkg::SCORE_W_DEF) - 1;
    localparam int CYCLE_CAP = 1000000;
    localparam int MAXL      = bga_pkg::MAX_SEQ_LEN_DEF;
    localparam int TW        = bga_pkg::TYPE_W;
    localparam int PW        = bga_pkg::POS_W;
    localparam int CW        = bga_pkg::CNT_W;
    localparam int IW        = bga_pkg::CFG_IDX_W;
    localparam int LW        = bga_pkg::LEN_W;

    // one expected or observed result word
    typedef struct {
        logic [TW-1:0] kind;
        logic [PW-1:0] row;
        logic [PW-1:0] col;
        logic [CW-1:0] count;
        logic          last;
    } edit_t;

    // alignment predictor plus the queue of edits still owed by the block
    class edit_scoreboard;
        int unsigned len_reg, mis_cost, open_cost, ext_cost;
        logic [1:0]  row_bases[MAXL];
        logic [1:0]  col_bases[MAXL];
        int unsigned score[SIDE*SIDE];
        logic [1:0]  dir[SIDE*SIDE];
        int unsigned vgap[SIDE];
        int unsigned loaded;
        edit_t       pending[$];
        int          errors;
        int          seen;

        function new();
            len_reg = 32; mis_cost = 1; open_cost = 2; ext_cost = 1;
            loaded = 0; errors = 0; seen = 0;
        endfunction

        function void set_reg(logic [IW-1:0] idx, int unsigned val);
            case (idx)
                bga_pkg::CFG_SEQ_LEN:    len_reg = val & 63;
                bga_pkg::CFG_MISMATCH:   mis_cost = val & 31;
                bga_pkg::CFG_GAP_OPEN:   open_cost = val & 31;
                bga_pkg::CFG_GAP_EXTEND: ext_cost = val & 31;
                default: ;
            endcase
        endfunction

        function int unsigned sat(int unsigned a, int unsigned b);
            return (a + b > SCORE_TOP) ? SCORE_TOP : a + b;
        endfunction

        function int unsigned lesser(int unsigned a, int unsigned b);
            return (a < b) ? a : b;
        endfunction

        function int unsigned eff_len();
            if (len_reg < bga_pkg::MIN_LEN) return bga_pkg::MIN_LEN;
            if (len_reg > MAXL) return MAXL;
            return len_reg;
        endfunction

        function bit banded(int unsigned i, int unsigned j, int unsigned m);
            int unsigned d;
            if (i < 1 || j < 1 || i >= m || j >= m) return 0;
            d = (i > j) ? i - j : j - i;
            return d < HALF;
        endfunction

        function void push_error(int unsigned i, int unsigned j);
            edit_t e;
            e.kind = bga_pkg::ED_ERR; e.row = i[PW-1:0]; e.col = j[PW-1:0];
            e.count = 1; e.last = 1;
            pending.push_back(e);
        endfunction

        // fill the band, pick the best end cell and trace back
        function void run_alignment();
            int unsigned m, i, j, lo, hi, p, q, g, d, r0, best, bi, bj, n;
            int unsigned hgap;
            logic [1:0]  dd;
            logic [TW-1:0] ty[bga_pkg::MAX_RES];
            int unsigned ro[bga_pkg::MAX_RES], co[bga_pkg::MAX_RES];
            logic [TW-1:0] e;
            edit_t w;
            m = eff_len() + 1;
            for (int k = 0; k < SIDE*SIDE; k++) score[k] = 0;
            for (int unsigned k = 0; k <= HALF && k < m; k++) begin
                score[k*SIDE] = lesser(k * mis_cost, SCORE_TOP);
                score[k] = lesser(k * mis_cost, SCORE_TOP);
                vgap[k] = bga_pkg::EDGE_VAL;
            end
            for (i = 1; i < m; i++) begin
                lo = 1; hi = i + HALF - 1;
                if (i >= HALF) begin
                    lo = i - HALF + 1;
                    score[i*SIDE + lo - 1] = bga_pkg::EDGE_VAL;
                end
                if (hi > m - 1) hi = m - 1;
                hgap = bga_pkg::EDGE_VAL;
                for (j = lo; j <= hi; j++) begin
                    p = lesser(sat(score[i*SIDE + j - 1], open_cost), sat(hgap, ext_cost));
                    q = lesser(sat(score[(i-1)*SIDE + j], open_cost),
                               sat(vgap[j], ext_cost));
                    if (p < q) begin
                        g = p; dd = bga_pkg::DIR_INS;
                    end else begin
                        g = q; dd = bga_pkg::DIR_DEL;
                    end
                    d = score[(i-1)*SIDE + j - 1];
                    if (row_bases[i-1] != col_bases[j-1]) d = sat(d, mis_cost);
                    if (d < g) begin
                        g = d; dd = bga_pkg::DIR_SUB;
                    end
                    score[i*SIDE + j] = g;
                    dir[i*SIDE + j] = dd;
                    hgap = p;
                    vgap[j] = q;
                end
                if (i + HALF <= m - 1) begin
                    score[i*SIDE + i + HALF] = bga_pkg::EDGE_VAL;
                    vgap[i + HALF] = bga_pkg::EDGE_VAL;
                end
            end
            // last column first, then last row; strictly smaller wins
            r0 = (m > HALF) ? m - HALF : 1;
            if (r0 < 1) r0 = 1;
            best = bga_pkg::EDGE_VAL; bi = 0; bj = 0;
            for (int unsigned k = r0; k < m; k++)
                if (score[k*SIDE + m - 1] < best) begin
                    best = score[k*SIDE + m - 1]; bi = k; bj = m - 1;
                end
            for (int unsigned k = r0; k < m; k++)
                if (score[(m-1)*SIDE + k] < best) begin
                    best = score[(m-1)*SIDE + k]; bi = m - 1; bj = k;
                end
            i = bi; j = bj;
            // strip trailing gaps
            forever begin
                if (!banded(i, j, m)) begin
                    push_error(i, j);
                    return;
                end
                dd = dir[i*SIDE + j];
                if (dd == bga_pkg::DIR_SUB) break;
                else if (dd == bga_pkg::DIR_INS) j--;
                else if (dd == bga_pkg::DIR_DEL) i--;
                else begin
                    push_error(i, j);
                    return;
                end
            end
            ty[0] = bga_pkg::ED_END; ro[0] = 0; co[0] = 0; n = 1;
            while (i > 1 && j > 1) begin
                if (!banded(i, j, m)) begin
                    push_error(i, j);
                    return;
                end
                dd = dir[i*SIDE + j];
                if (dd == bga_pkg::DIR_SUB) begin
                    i--; j--;
                    // unchanged score on the diagonal: no edit
                    if (score[i*SIDE + j] == score[(i-1)*SIDE + j - 1]) continue;
                    e = bga_pkg::ED_SUB;
                end else if (dd == bga_pkg::DIR_INS) begin
                    j--; e = bga_pkg::ED_INS;
                end else if (dd == bga_pkg::DIR_DEL) begin
                    i--; e = bga_pkg::ED_DEL;
                end else begin
                    push_error(i, j);
                    return;
                end
                if (n < bga_pkg::MAX_RES) begin
                    ty[n] = e; ro[n] = i; co[n] = j; n++;
                end
            end
            for (int unsigned k = 0; k < n; k++) begin
                w.kind = ty[k]; w.row = ro[k][PW-1:0]; w.col = co[k][PW-1:0];
                w.count = n[CW-1:0]; w.last = (k + 1 == n);
                pending.push_back(w);
            end
        endfunction

        function void note_input(logic [1:0] fb, logic [1:0] sb);
            if (loaded < MAXL) begin
                row_bases[loaded] = fb;
                col_bases[loaded] = sb;
            end
            loaded++;
            if (loaded >= eff_len()) begin
                loaded = 0;
                run_alignment();
            end
        endfunction

        function void check_result(edit_t got);
            edit_t want;
            seen++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: type %0d row %0d col %0d count %0d last %0d",
                             got.kind, got.row, got.col, got.count, got.last);
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind || got.row !== want.row || got.col !== want.col ||
                got.count !== want.count || got.last !== want.last) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                             want.kind, want.row, want.col, want.count, want.last,
                             got.kind, got.row, got.col, got.count, got.last);
            end
        endfunction
    endclass

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [7:0]    s_tdata;   // first_base[1:0], second_base[3:2], zero pad
    logic          m_tvalid;
    logic          m_tready;
    logic [23:0]   m_tdata;   // edit_type[2:0], row_pos[8:3], col_pos[14:9],
                              // edit_count[21:15], zero pad
    logic          m_tlast;   // last_edit
    logic          cfg_wr_en;
    logic [IW-1:0] cfg_index;
    logic [LW-1:0] cfg_wdata;

    edit_scoreboard sb = new();
    bit idle_on  = 1;   // random idling on both sides
    int words_in = 0;
    int cycles   = 0;
    bit hold_done = 0;
    int stall_left = 0;

    banded_affine_gap_alignment u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0; #5;
        aclk = 1'b1; #5;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("tb failed");
            $finish;
        end
    end

    // result monitor, sampled on the rising edge
    always @(posedge aclk) begin
        edit_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind  = m_tdata[2:0];
            got.row   = m_tdata[8:3];
            got.col   = m_tdata[14:9];
            got.count = m_tdata[21:15];
            got.last  = m_tlast;
            sb.check_result(got);
        end
    end

    // receiver: random stall bursts, plus one long hold-off while the sender is offering
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_tready = 1'b0;
            end else if (!hold_done && sb.seen >= 5 && s_tvalid && m_tvalid) begin
                hold_done = 1;
                stall_left = 3000;
                m_tready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 9);
                m_tready = 1'b0;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // offer one word; called just after a falling edge, returns just after a falling edge
    task automatic push_word(input logic [1:0] fb, input logic [1:0] sbase);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {4'b0, sbase, fb};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(fb, sbase);
        words_in++;
        if (words_in > 400) idle_on = 0;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_reg(input logic [IW-1:0] idx, input int unsigned val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val[LW-1:0];
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.set_reg(idx, val);
    endtask

    // wait for every owed edit, then let the block go quiet
    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    // one sequence pair: mostly similar sequences with point changes and at times a shift
    task automatic send_pair(input int unsigned n, input bit noisy);
        logic [1:0] a[MAXL+8];
        logic [1:0] b[MAXL+8];
        int shift_at, shift;
        foreach (a[k]) a[k] = $urandom_range(0, 3);
        shift_at = $urandom_range(0, n);
        shift = $urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 0;
        foreach (b[k]) begin
            if (noisy) b[k] = $urandom_range(0, 3);
            else if (k >= shift_at && k + shift < $size(a)) b[k] = a[k + shift];
            else b[k] = a[k];
            if (!noisy && $urandom_range(0, 9) == 0) b[k] = $urandom_range(0, 3);
        end
        if ($urandom_range(0, 1)) begin
            for (int k = 0; k < n; k++) push_word(a[k], b[k]);
        end else begin
            for (int k = 0; k < n; k++) push_word(b[k], a[k]);
        end
    endtask

    initial begin
        int unsigned lens[4];
        int unsigned costs[4][3];
        int phase;
        int unsigned len;
        lens  = '{63, 16, 32, 0};
        costs = '{'{0, 0, 0}, '{31, 31, 31}, '{31, 0, 0}, '{0, 31, 31}};
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = bga_pkg::CFG_SEQ_LEN;
        cfg_wdata = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: extreme bases at reset costs, length shortened mid-load
        write_reg(bga_pkg::CFG_SEQ_LEN, 20);
        for (int k = 0; k < 18; k++)
            push_word(k[0] ? 2'd3 : 2'd0, k[1] ? 2'd0 : 2'd3);
        write_reg(bga_pkg::CFG_SEQ_LEN, 0);
        push_word(2'd3, 2'd3);
        drain();

        // random phases, extreme settings first
        phase = 0;
        while (words_in < 440) begin
            if (phase < 4) begin
                write_reg(bga_pkg::CFG_SEQ_LEN, lens[phase]);
                write_reg(bga_pkg::CFG_MISMATCH, costs[phase][0]);
                write_reg(bga_pkg::CFG_GAP_OPEN, costs[phase][1]);
                write_reg(bga_pkg::CFG_GAP_EXTEND, costs[phase][2]);
            end else begin
                write_reg(bga_pkg::CFG_SEQ_LEN, $urandom_range(0, 3) == 0 ?
                          $urandom_range(0, 63) : $urandom_range(16, 24));
                write_reg(bga_pkg::CFG_MISMATCH, $urandom_range(0, 4) == 0 ?
                          $urandom_range(0, 31) : $urandom_range(1, 4));
                write_reg(bga_pkg::CFG_GAP_OPEN, $urandom_range(0, 4) == 0 ?
                          $urandom_range(0, 31) : $urandom_range(0, 6));
                write_reg(bga_pkg::CFG_GAP_EXTEND, $urandom_range(0, 4) == 0 ?
                          $urandom_range(0, 31) : $urandom_range(0, 3));
            end
            len = sb.eff_len();
            repeat (2) send_pair(len, $urandom_range(0, 4) == 0);
            drain();
            phase++;
        end

        repeat (200) @(negedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
